/* hw/rtl/hxp_pkg.sv */
package hxp_pkg;

	// Counter and result widths
	localparam int COUNT_BITS = 16;
	localparam int TOTAL_W    = 16;

	// Queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Character classes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	typedef enum logic [2:0] {
		CLS_WS,
		CLS_HEX,
		CLS_PLUS,
		CLS_MINUS,
		CLS_OTHER
	} cls_t;

	// Back-end decoder state
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_OPEN,
		ST_HALT
	} back_st_t;

	typedef struct packed {
		logic [7:0] char_in;
		logic       last_char;
	} in_t;

	typedef struct packed {
		logic [7:0]         byte_value;
		logic               byte_valid;
		logic               stream_end;
		logic               stopped_early;
		logic [TOTAL_W-1:0] byte_total;
	} out_t;

	// Classified character as it travels through the queue
	typedef struct packed {
		cls_t       cls;
		logic [3:0] digit;
		logic       last;
	} item_t;

	// Queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

/* hw/rtl/hex_text_to_bytes_parser_core.sv */
// Hex text decoder: takes one character per transfer and turns whitespace-separated
// codes of one or two hex characters (optionally signed) into bytes. A result is
// given for each decoded byte and for the last character of a text; the end result
// carries the saturated byte count and whether an invalid code halted decoding.
// One character is accepted per cycle while the queue has room; a character's result
// passes through the classification queue and the output register. Stall on
// the result side backs up through a two-entry queue before the input stalls.
module hex_text_to_bytes_parser_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          char_valid,
	output logic          char_stall,
	input  hxp_pkg::in_t  char_data,
	output logic          res_valid,
	input  logic          res_stall,
	output hxp_pkg::out_t res_data
);
	import hxp_pkg::*;

	q_stat_t q_stat;
	logic    push;
	logic    pop;
	item_t   push_item;
	item_t   pop_item;

	hxp_front u_front (
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data),
		.q_stat     (q_stat),
		.push       (push),
		.push_item  (push_item)
	);

	hxp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.q_stat    (q_stat)
	);

	hxp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.pop_item  (pop_item),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

/* hw/rtl/hxp_front.sv */
module hxp_front (
	input  logic          char_valid,
	output logic          char_stall,
	input  hxp_pkg::in_t  char_data,
	input  hxp_pkg::q_stat_t q_stat,
	output logic          push,
	output hxp_pkg::item_t push_item
);
	import hxp_pkg::*;

	logic [7:0] c;

	assign c = char_data.char_in;

	// Stall while the queue has no room
	assign char_stall = q_stat.full;
	assign push       = char_valid && !q_stat.full;

	// Classify the character and extract its hex digit
	always_comb begin
		push_item.last  = char_data.last_char;
		push_item.digit = 4'd0;
		push_item.cls   = CLS_OTHER;
		if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
			push_item.cls = CLS_WS;
		end else if (c >= 8'h30 && c <= 8'h39) begin
			push_item.cls   = CLS_HEX;
			push_item.digit = c[3:0];
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			push_item.cls   = CLS_HEX;
			push_item.digit = c[3:0] + 4'd9;
		end else if (c == CH_PLUS) begin
			push_item.cls = CLS_PLUS;
		end else if (c == CH_MINUS) begin
			push_item.cls = CLS_MINUS;
		end
	end

endmodule

/* hw/rtl/hxp_queue.sv */
module hxp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  hxp_pkg::item_t   push_item,
	input  logic             pop,
	output hxp_pkg::item_t   pop_item,
	output hxp_pkg::q_stat_t q_stat
);
	import hxp_pkg::*;

	item_t               entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]  wr_ptr_q;
	logic [Q_PTR_W-1:0]  rd_ptr_q;
	logic [Q_CNT_W-1:0]  cnt_q;

	assign q_stat.full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign pop_item     = entry_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Store pushed items
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* hw/rtl/hxp_back.sv */
module hxp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  hxp_pkg::q_stat_t q_stat,
	input  hxp_pkg::item_t   pop_item,
	output logic             pop,
	output logic             res_valid,
	input  logic             res_stall,
	output hxp_pkg::out_t    res_data
);
	import hxp_pkg::*;

	localparam int WIDE_W = COUNT_BITS + TOTAL_W;

	back_st_t              st_q;
	back_st_t              st_nxt;
	cls_t                  fcls_q;
	logic [3:0]            fdig_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic [WIDE_W-1:0]     cnt_wide;
	logic                  out_valid_q;
	out_t                  out_q;

	logic       got;
	logic       fail;
	logic [7:0] val;
	out_t       res;

	// Take an item when the output register is free or draining
	assign pop = !q_stat.empty && (!out_valid_q || !res_stall);

	// Decode the current code
	always_comb begin
		got  = 1'b0;
		fail = 1'b0;
		val  = 8'd0;
		unique case (st_q)
			ST_IDLE: begin
				if (pop_item.cls != CLS_WS && pop_item.last) begin
					if (pop_item.cls == CLS_HEX) begin
						got = 1'b1;
						val = {4'd0, pop_item.digit};
					end else begin
						fail = 1'b1;
					end
				end
			end
			ST_OPEN: begin
				if (pop_item.cls == CLS_WS) begin
					if (fcls_q == CLS_HEX) begin
						got = 1'b1;
						val = {4'd0, fdig_q};
					end else begin
						fail = 1'b1;
					end
				end else if (pop_item.cls != CLS_HEX) begin
					fail = 1'b1;
				end else begin
					case (fcls_q)
						CLS_HEX: begin
							got = 1'b1;
							val = {fdig_q, pop_item.digit};
						end
						CLS_PLUS: begin
							got = 1'b1;
							val = {4'd0, pop_item.digit};
						end
						CLS_MINUS: begin
							got = 1'b1;
							val = 8'd0 - {4'd0, pop_item.digit};
						end
						default: begin
							fail = 1'b1;
						end
					endcase
				end
			end
			ST_HALT: begin
				got = 1'b0;
			end
			default: begin
				got = 1'b0;
			end
		endcase
	end

	// Next state
	always_comb begin
		st_nxt = st_q;
		if (pop_item.last) begin
			st_nxt = ST_IDLE;
		end else begin
			unique case (st_q)
				ST_IDLE: st_nxt = (pop_item.cls == CLS_WS) ? ST_IDLE : ST_OPEN;
				ST_OPEN: st_nxt = fail ? ST_HALT : ST_IDLE;
				ST_HALT: st_nxt = ST_HALT;
				default: st_nxt = ST_IDLE;
			endcase
		end
	end

	// Saturating count and the clipped total
	assign cnt_inc  = (got && cnt_q != '1) ? cnt_q + 1'b1 : cnt_q;
	assign cnt_wide = {{TOTAL_W{1'b0}}, cnt_inc};

	always_comb begin
		res.byte_value    = val;
		res.byte_valid    = got;
		res.stream_end    = pop_item.last;
		res.stopped_early = (st_q == ST_HALT) || fail;
		res.byte_total    = (cnt_wide > WIDE_W'({TOTAL_W{1'b1}})) ?
			{TOTAL_W{1'b1}} : cnt_wide[TOTAL_W-1:0];
	end

	// Hold decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			cnt_q <= '0;
		end else if (pop) begin
			st_q  <= st_nxt;
			cnt_q <= pop_item.last ? '0 : cnt_inc;
		end
	end

	// Capture the first character of a code
	always_ff @(posedge clk) begin
		if (pop && st_q == ST_IDLE && pop_item.cls != CLS_WS) begin
			fcls_q <= pop_item.cls;
			fdig_q <= pop_item.digit;
		end
	end

	// Output register: load a result, drop it once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= got || pop_item.last;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && (got || pop_item.last)) begin
			out_q <= res;
		end
	end

	assign res_valid = out_valid_q;
	assign res_data  = out_q;

endmodule

/* hw/rtl/hxp_checker.sv */
module hxp_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          char_valid,
	input logic          char_stall,
	input hxp_pkg::in_t  char_data,
	input logic          res_valid,
	input logic          res_stall,
	input hxp_pkg::out_t res_data
);
	import hxp_pkg::*;

	// Hold a stalled result
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	// A result that does not end the text carries a byte
	a_mid_byte: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.stream_end |-> res_data.byte_valid)
		else $error("empty result before end of text");

	// A decoded byte is counted
	a_byte_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.byte_valid |-> res_data.byte_total != '0)
		else $error("byte with zero total");

	// A decoded byte never comes with a halt
	a_byte_no_halt: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.byte_valid |-> !res_data.stopped_early)
		else $error("byte reported on halted stream");

endmodule

bind hex_text_to_bytes_parser_core hxp_checker u_hxp_checker (.*);

/* tb/tb_hex_text_to_bytes_parser_core.sv */
`timescale 1ns / 100ps

module tb_hex_text_to_bytes_parser_core;

	import hxp_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 150;
	localparam int RANDOM_ITEMS = 1650;

	localparam out_t NO_RES = '0;

	// One directed stimulus row; res is used only when typed is set
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       typed;
		logic       has_res;
		out_t       res;
	} row_t;

	localparam int N_ROWS = 26;
	localparam row_t DIR_ROWS [N_ROWS] = '{
		'{8'h30, 1'b0, 1'b1, 1'b0, NO_RES},
		'{8'h30, 1'b0, 1'b1, 1'b1, {8'h00, 1'b1, 1'b0, 1'b0, 16'd1}},
		'{8'h20, 1'b0, 1'b0, 1'b0, NO_RES},
		'{8'h46, 1'b0, 1'b0, 1'b0, NO_RES},
		'{8'h66, 1'b0, 1'b1, 1'b1, {8'hFF, 1'b1, 1'b0, 1'b0, 16'd2}},
		'{8'h09, 1'b0, 1'b0, 1'b0, NO_RES},
		'{8'h2D, 1'b0, 1'b0, 1'b0, NO_RES},
		'{8'h31, 1'b0, 1'b1, 1'b1, {8'hFF, 1'b1, 1'b0, 1'b0, 16'd3}},
		'{8'h2B, 1'b0, 1'b0, 1'b0, NO_RES},
		'{8'h61, 1'b0, 1'b0, 1'b0, NO_RES},
		'{8'h41, 1'b0, 1'b0, 1'b0, NO_RES},
		'{8'h0B, 1'b0, 1'b0, 1'b0, NO_RES},
		'{8'h0C, 1'b0, 1'b0, 1'b0, NO_RES},
		'{8'h39, 1'b1, 1'b0, 1'b0, NO_RES},
		'{8'h30, 1'b0, 1'b0, 1'b0, NO_RES},
		'{8'h78, 1'b0, 1'b1, 1'b0, NO_RES},
		'{8'h35, 1'b0, 1'b1, 1'b0, NO_RES},
		'{8'hFF, 1'b1, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, 1'b1, 16'd0}},
		'{8'h67, 1'b1, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, 1'b1, 16'd0}},
		'{8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
		'{8'h80, 1'b0, 1'b0, 1'b0, NO_RES},
		'{8'h0D, 1'b1, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, 1'b1, 16'd0}},
		'{8'h2D, 1'b0, 1'b0, 1'b0, NO_RES},
		'{8'h46, 1'b0, 1'b1, 1'b1, {8'hF1, 1'b1, 1'b0, 1'b0, 16'd1}},
		'{8'h20, 1'b1, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, 1'b0, 16'd1}},
		'{8'h0A, 1'b1, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, 1'b0, 16'd0}}
	};

	localparam logic [7:0] BLANKS [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
	localparam string HEX_CHARS = "0123456789abcdefABCDEF";

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic char_valid = 1'b0;
	logic char_stall;
	in_t  char_data = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	out_t res_data;

	// Decoder state mirrored by the predictor
	bit                    dec_open;
	logic [7:0]            dec_first;
	bit                    dec_halted;
	logic [COUNT_BITS-1:0] dec_count;

	out_t bytes_due [$];
	int   errors;
	int   items_sent;
	int   quiet_cycles;
	int   hold_left;
	bit   sender_idles = 1'b1;
	bit   receiver_idles = 1'b1;

	hex_text_to_bytes_parser_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_data   (res_data)
	);

	always #5 clk = ~clk;

	function automatic int hex_digit(logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c) - 48;
		if (c >= "A" && c <= "F") return int'(c) - 55;
		if (c >= "a" && c <= "f") return int'(c) - 87;
		return -1;
	endfunction

	function automatic bit is_blank(logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic void bump_count();
		if (dec_count != '1) dec_count = dec_count + 1'b1;
	endfunction

	// Advance the decoder by one character; return 1 when it yields a result
	function automatic bit decode_char(input in_t it, output out_t res);
		int d0;
		int d1;
		bit ok;
		bit got;
		logic [7:0] val;
		got = 1'b0;
		val = 8'h00;
		res = '0;
		if (!dec_halted) begin
			if (!dec_open) begin
				if (!is_blank(it.char_in)) begin
					dec_first = it.char_in;
					dec_open = 1'b1;
				end
			end else begin
				d0 = hex_digit(dec_first);
				d1 = hex_digit(it.char_in);
				if (is_blank(it.char_in)) begin
					ok = d0 >= 0;
					val = 8'(d0);
				end else if (d1 < 0) begin
					ok = 1'b0;
				end else if (d0 >= 0) begin
					ok = 1'b1;
					val = 8'(d0 * 16 + d1);
				end else if (dec_first == "+") begin
					ok = 1'b1;
					val = 8'(d1);
				end else if (dec_first == "-") begin
					ok = 1'b1;
					val = 8'(256 - d1);
				end else begin
					ok = 1'b0;
				end
				dec_open = 1'b0;
				if (ok) begin
					bump_count();
					got = 1'b1;
				end else begin
					dec_halted = 1'b1;
				end
			end
			// Flush a pending one-character code on the last character
			if (it.last_char && dec_open) begin
				d0 = hex_digit(dec_first);
				dec_open = 1'b0;
				if (d0 >= 0) begin
					val = 8'(d0);
					bump_count();
					got = 1'b1;
				end else begin
					dec_halted = 1'b1;
				end
			end
		end
		if (!got && !it.last_char) return 1'b0;
		res.byte_value = got ? val : 8'h00;
		res.byte_valid = got;
		res.stream_end = it.last_char;
		res.stopped_early = dec_halted;
		res.byte_total = (dec_count > 16'hFFFF) ? '1 : TOTAL_W'(dec_count);
		if (it.last_char) begin
			dec_open = 1'b0;
			dec_first = 8'h00;
			dec_halted = 1'b0;
			dec_count = '0;
		end
		return 1'b1;
	endfunction

	// Offer one character and hold it until the transfer
	task automatic send_char(input in_t it);
		while (sender_idles && $urandom_range(99) < 6) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_data <= it;
		char_valid <= 1'b1;
		@(posedge clk);
		while (char_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic feed_char(input logic [7:0] c, input logic last);
		in_t it;
		out_t res;
		it.char_in = c;
		it.last_char = last;
		if (decode_char(it, res)) bytes_due.push_back(res);
		send_char(it);
	endtask

	function automatic logic [7:0] pick_blank();
		return BLANKS[$urandom_range(5)];
	endfunction

	function automatic logic [7:0] pick_hex();
		return HEX_CHARS[$urandom_range(HEX_CHARS.len() - 1)];
	endfunction

	// Build a text of mostly valid codes, with an occasional corrupted one
	task automatic send_code_text(input int n_codes);
		logic [7:0] txt [$];
		int kind;
		int nb;
		if ($urandom_range(3) == 0) txt.push_back(pick_blank());
		for (int k = 0; k < n_codes; k++) begin
			kind = $urandom_range(3);
			case (kind)
				0: txt.push_back(pick_hex());
				1: begin
					txt.push_back(pick_hex());
					txt.push_back(pick_hex());
				end
				2: begin
					txt.push_back("+");
					txt.push_back(pick_hex());
				end
				default: begin
					txt.push_back("-");
					txt.push_back(pick_hex());
				end
			endcase
			if ($urandom_range(99) < 6) txt[txt.size() - 1 - $urandom_range(kind != 0)] =
				8'($urandom_range(255));
			if (k < n_codes - 1 || $urandom_range(1)) begin
				nb = (kind != 0 && $urandom_range(4) == 0) ? 0 : $urandom_range(1, 2);
				repeat (nb) txt.push_back(pick_blank());
			end
		end
		if (txt.size() == 0) txt.push_back(pick_blank());
		foreach (txt[j]) feed_char(txt[j], j == txt.size() - 1);
	endtask

	task automatic send_noise_text();
		int len;
		len = $urandom_range(1, 12);
		for (int j = 0; j < len; j++) feed_char(8'($urandom_range(255)), j == len - 1);
	endtask

	// Receiver stall: long hold-off on request, else random stalls while receiver_idles is set
	always @(posedge clk) begin
		if (hold_left > 0) begin
			res_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			res_stall <= receiver_idles && ($urandom_range(99) < 6);
		end
	end

	// Check each result transfer against the oldest expectation
	always @(posedge clk) begin : check_results
		out_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (bytes_due.size() == 0) begin
				$error("unexpected result: %h", res_data);
				errors++;
			end else begin
				want = bytes_due.pop_front();
				if (res_data.byte_value !== want.byte_value) begin
					$error("byte_value: expected %h, got %h", want.byte_value,
						res_data.byte_value);
					errors++;
				end
				if (res_data.byte_valid !== want.byte_valid) begin
					$error("byte_valid: expected %b, got %b", want.byte_valid,
						res_data.byte_valid);
					errors++;
				end
				if (res_data.stream_end !== want.stream_end) begin
					$error("stream_end: expected %b, got %b", want.stream_end,
						res_data.stream_end);
					errors++;
				end
				if (res_data.stopped_early !== want.stopped_early) begin
					$error("stopped_early: expected %b, got %b", want.stopped_early,
						res_data.stopped_early);
					errors++;
				end
				if (res_data.byte_total !== want.byte_total) begin
					$error("byte_total: expected %0d, got %0d", want.byte_total,
						res_data.byte_total);
					errors++;
				end
			end
		end
	end

	// Abort when no transfer happens on either side for too long
	always @(posedge clk) begin
		if ((char_valid && !char_stall) || (res_valid && !res_stall))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$error("no transfer for %0d cycles", QUIET_LIMIT);
			$display("tb_hex_text_to_bytes_parser_core: errors");
			$finish;
		end
	end

	initial begin
		in_t it;
		out_t res;
		int random_start;
		dec_open = 1'b0;
		dec_first = 8'h00;
		dec_halted = 1'b0;
		dec_count = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: typed rows supply their own expectation
		for (int r = 0; r < N_ROWS; r++) begin
			it.char_in = DIR_ROWS[r].ch;
			it.last_char = DIR_ROWS[r].last;
			if (decode_char(it, res) && !DIR_ROWS[r].typed) bytes_due.push_back(res);
			if (DIR_ROWS[r].typed && DIR_ROWS[r].has_res) bytes_due.push_back(DIR_ROWS[r].res);
			send_char(it);
		end

		// Random texts, starting with a stretch without idling
		random_start = items_sent;
		sender_idles = 1'b0;
		receiver_idles = 1'b0;
		while (items_sent < random_start + 400) send_code_text($urandom_range(0, 10));
		sender_idles = 1'b1;
		receiver_idles = 1'b1;

		// Hold off the receiver while characters keep coming
		hold_left = HOLD_CYCLES;
		send_code_text(40);

		while (items_sent < random_start + RANDOM_ITEMS) begin
			if ($urandom_range(99) < 15)
				send_noise_text();
			else
				send_code_text($urandom_range(0, 10));
		end
		char_valid <= 1'b0;

		while (bytes_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0 && bytes_due.size() == 0) begin
			$display("tb_hex_text_to_bytes_parser_core: clean");
		end else begin
			$display("tb_hex_text_to_bytes_parser_core: errors");
		end
		$finish;
	end

endmodule
